/* hw/rtl/tlcrg_pkg.sv */
// Shared types and constants for the thin-lens camera ray generator.
`timescale 1ns / 1ps
`default_nettype none
package tlcrg_pkg;

  // Register map
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 48;

  typedef enum logic [CFG_IW-1:0] {
    REG_CAM_POS   = 3'd0,
    REG_FORWARD   = 3'd1,
    REG_RIGHT     = 3'd2,
    REG_UP        = 3'd3,
    REG_FOCUS     = 3'd4,
    REG_APERTURE  = 3'd5,
    REG_PLANE     = 3'd6,
    REG_CLIP      = 3'd7
  } reg_idx_t;

  localparam logic [15:0] FOCUS_RST = 16'h0100;
  localparam logic [31:0] PLANE_RST = 32'h2000_2000;
  localparam logic [31:0] CLIP_RST  = 32'hFFFF_0000;

  // Odd sine polynomial coefficients, quarter turn in Q.14
  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [29:0] SIN_C3 = 30'd693598668;
  localparam logic [26:0] SIN_C5 = 27'd85569306;
  localparam logic [22:0] SIN_C7 = 23'd5026995;
  localparam logic [15:0] ONE_Q14 = 16'd16384;

  // Queue between front and back
  localparam int QDEPTH = 32;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [47:0] cam_pos;
    logic [47:0] fwd_axis;
    logic [47:0] right_axis;
    logic [47:0] up_axis;
    logic [15:0] focus;
    logic [15:0] aperture;
    logic [31:0] plane;
    logic [31:0] clip;
  } cfg_t;

  // Front result: lens origin, |target - origin| per axis with sign, and sum of squares
  typedef struct packed {
    logic [2:0][27:0] org;
    logic [2:0][29:0] mag;
    logic [2:0]       neg;
    logic [61:0]      sumsq;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

/* hw/rtl/tlcrg_if.sv */
// Handshake channels: pixel samples in, rays out.
`timescale 1ns / 1ps
`default_nettype none
interface tlcrg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [15:0] lens_angle;
  logic [15:0] lens_radius_fraction;

  modport source(output valid, pixel_x, pixel_y, lens_angle, lens_radius_fraction,
                 input ready);
  modport sink(input valid, pixel_x, pixel_y, lens_angle, lens_radius_fraction,
               output ready);
endinterface

interface tlcrg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic signed [15:0] origin_z;
  logic signed [15:0] direction_x;
  logic signed [15:0] direction_y;
  logic signed [15:0] direction_z;
  logic        [15:0] ray_length;

  modport source(output valid, origin_x, origin_y, origin_z, direction_x, direction_y,
                 direction_z, ray_length, input ready);
  modport sink(input valid, origin_x, origin_y, origin_z, direction_x, direction_y,
               direction_z, ray_length, output ready);
endinterface
`default_nettype wire

/* hw/rtl/tlcrg_front.sv */
// Front pipeline: lens sample, focus-plane target and squared distance per beat.
`timescale 1ns / 1ps
`default_nettype none
module tlcrg_front import tlcrg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  tlcrg_in_if.sink pixel,
  input  cfg_t   cfg,
  input  logic   pop,
  output logic   push,
  output qent_t  push_data
);

  localparam int FL = 15;

  typedef enum logic [1:0] {
    Q_FIRST  = 2'd0,
    Q_SECOND = 2'd1,
    Q_THIRD  = 2'd2,
    Q_FOURTH = 2'd3
  } quad_t;

  logic           take;
  logic [QAW:0]   credit;
  logic [FL-1:0]  vld;

  // credit covers beats in flight here plus those held in the queue
  assign take        = pixel.valid && pixel.ready;
  assign pixel.ready = credit < (QAW+1)'(QDEPTH);
  assign push        = vld[FL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
      vld    <= '0;
    end else begin
      credit <= credit + (QAW+1)'(take) - (QAW+1)'(pop);
      vld    <= {vld[FL-2:0], take};
    end
  end

  // configuration decode
  logic signed [16:0] focus_s;
  logic signed [15:0] fw [3];
  logic signed [15:0] rt [3];
  logic signed [15:0] upv [3];
  logic signed [23:0] pos [3];

  always_comb begin
    focus_s = $signed({1'b0, cfg.focus});
    for (int i = 0; i < 3; i++) begin
      fw[i]  = $signed(cfg.fwd_axis[47-16*i -: 16]);
      rt[i]  = $signed(cfg.right_axis[47-16*i -: 16]);
      upv[i] = $signed(cfg.up_axis[47-16*i -: 16]);
      pos[i] = $signed({cfg.cam_pos[47-16*i -: 16], 8'h00});
    end
  end

  // S0: input beat
  logic [15:0] px0, py0, ang0, frac0;
  always_ff @(posedge clk) begin
    px0   <= pixel.pixel_x;
    py0   <= pixel.pixel_y;
    ang0  <= pixel.lens_angle;
    frac0 <= pixel.lens_radius_fraction;
  end

  // S1: squares of the sine argument, lens radius, plane offset first product
  logic [14:0]        ua1, ub1, x2a1, x2b1;
  logic [31:0]        rad1;
  logic signed [32:0] pw1, ph1;
  logic [1:0]         quad1;
  logic [14:0]        ua0, ub0;
  logic [29:0]        sqa0, sqb0;

  always_comb begin
    ua0  = {1'b0, ang0[13:0]};
    ub0  = 15'(ONE_Q14) - ua0;
    sqa0 = ua0 * ua0;
    sqb0 = ub0 * ub0;
  end

  always_ff @(posedge clk) begin
    ua1   <= ua0;
    ub1   <= ub0;
    x2a1  <= sqa0[28:14];
    x2b1  <= sqb0[28:14];
    rad1  <= cfg.aperture * frac0;
    pw1   <= $signed({1'b0, cfg.plane[31:16]}) * $signed({~px0[15], px0[14:0]});
    ph1   <= $signed({1'b0, cfg.plane[15:0]}) * $signed({~py0[15], py0[14:0]});
    quad1 <= ang0[15:14];
  end

  // S2: first Horner step, plane offset times focus
  logic [14:0]        ua2, ub2, x2a2, x2b2;
  logic [31:0]        rad2;
  logic [1:0]         quad2;
  logic [26:0]        acc5a2, acc5b2;
  logic signed [49:0] xop2, yop2;
  logic [37:0]        p7a, p7b;

  always_comb begin
    p7a = SIN_C7 * x2a1;
    p7b = SIN_C7 * x2b1;
  end

  always_ff @(posedge clk) begin
    ua2    <= ua1;
    ub2    <= ub1;
    x2a2   <= x2a1;
    x2b2   <= x2b1;
    rad2   <= rad1;
    quad2  <= quad1;
    acc5a2 <= SIN_C5 - 27'(p7a >> 14);
    acc5b2 <= SIN_C5 - 27'(p7b >> 14);
    xop2   <= pw1 * focus_s;
    yop2   <= ph1 * focus_s;
  end

  // S3: second Horner step, round plane offsets (y axis points up)
  logic [14:0]        ua3, ub3, x2a3, x2b3;
  logic [31:0]        rad3;
  logic [1:0]         quad3;
  logic [29:0]        acc3a3, acc3b3;
  logic signed [28:0] xo3, yo3;
  logic [41:0]        p5a, p5b;
  logic signed [50:0] xr_s, yr_s;

  always_comb begin
    p5a  = acc5a2 * x2a2;
    p5b  = acc5b2 * x2b2;
    xr_s = (51'(xop2) + 51'sd524288) >>> 20;
    yr_s = (-51'(yop2) + 51'sd524288) >>> 20;
  end

  always_ff @(posedge clk) begin
    ua3    <= ua2;
    ub3    <= ub2;
    x2a3   <= x2a2;
    x2b3   <= x2b2;
    rad3   <= rad2;
    quad3  <= quad2;
    acc3a3 <= SIN_C3 - 30'(p5a >> 14);
    acc3b3 <= SIN_C3 - 30'(p5b >> 14);
    xo3    <= 29'(xr_s);
    yo3    <= 29'(yr_s);
  end

  // S4: third Horner step, target products per axis
  logic [14:0]        ua4, ub4;
  logic [31:0]        rad4;
  logic [1:0]         quad4;
  logic [30:0]        acc1a4, acc1b4;
  logic signed [44:0] xr4 [3];
  logic signed [44:0] yu4 [3];
  logic signed [32:0] ff4 [3];
  logic [44:0]        p3a, p3b;

  always_comb begin
    p3a = acc3a3 * x2a3;
    p3b = acc3b3 * x2b3;
  end

  always_ff @(posedge clk) begin
    ua4    <= ua3;
    ub4    <= ub3;
    rad4   <= rad3;
    quad4  <= quad3;
    acc1a4 <= SIN_C1 - 31'(p3a >> 14);
    acc1b4 <= SIN_C1 - 31'(p3b >> 14);
    for (int i = 0; i < 3; i++) begin
      xr4[i] <= xo3 * rt[i];
      yu4[i] <= yo3 * upv[i];
      ff4[i] <= fw[i] * focus_s;
    end
  end

  // S5: last sine product, focus-plane target
  logic [31:0]        rad5;
  logic [1:0]         quad5;
  logic [15:0]        sa5, sb5;
  logic signed [31:0] tgt5 [3];
  logic [45:0]        fa, fb;
  logic signed [32:0] r6 [3];
  logic signed [44:0] rx [3];
  logic signed [44:0] ry [3];

  always_comb begin
    fa = acc1a4 * ua4 + 46'd536870912;
    fb = acc1b4 * ub4 + 46'd536870912;
    for (int i = 0; i < 3; i++) begin
      r6[i] = (ff4[i] + 33'sd32) >>> 6;
      rx[i] = (xr4[i] + 45'sd8192) >>> 14;
      ry[i] = (yu4[i] + 45'sd8192) >>> 14;
    end
  end

  always_ff @(posedge clk) begin
    rad5  <= rad4;
    quad5 <= quad4;
    sa5   <= fa[45:30];
    sb5   <= fb[45:30];
    for (int i = 0; i < 3; i++)
      tgt5[i] <= 32'(pos[i]) + 32'(r6[i]) + 32'(rx[i]) + 32'(ry[i]);
  end

  // S6: clamp to 1.0 and unfold the quadrant
  logic [31:0]        rad6;
  logic signed [31:0] tgt6 [3];
  logic signed [15:0] sn6, cs6;
  logic signed [15:0] ca, cb, sn_c, cs_c;

  always_comb begin
    ca = $signed((sa5 > ONE_Q14) ? ONE_Q14 : sa5);
    cb = $signed((sb5 > ONE_Q14) ? ONE_Q14 : sb5);
    case (quad_t'(quad5))
      Q_FIRST:  begin sn_c = ca;  cs_c = cb;  end
      Q_SECOND: begin sn_c = cb;  cs_c = -ca; end
      Q_THIRD:  begin sn_c = -ca; cs_c = -cb; end
      Q_FOURTH: begin sn_c = -cb; cs_c = ca;  end
      default:  begin sn_c = ca;  cs_c = cb;  end
    endcase
  end

  always_ff @(posedge clk) begin
    rad6 <= rad5;
    sn6  <= sn_c;
    cs6  <= cs_c;
    for (int i = 0; i < 3; i++) tgt6[i] <= tgt5[i];
  end

  // S7: lens offsets on the right/up plane
  logic signed [48:0] lxp7, lyp7;
  logic signed [31:0] tgt7 [3];

  always_ff @(posedge clk) begin
    lxp7 <= $signed({1'b0, rad6}) * cs6;
    lyp7 <= $signed({1'b0, rad6}) * sn6;
    for (int i = 0; i < 3; i++) tgt7[i] <= tgt6[i];
  end

  // S8: round lens offsets to Q.16
  logic signed [25:0] lx8, ly8;
  logic signed [31:0] tgt8 [3];
  logic signed [48:0] lxr, lyr;

  always_comb begin
    lxr = (lxp7 + 49'sd2097152) >>> 22;
    lyr = (lyp7 + 49'sd2097152) >>> 22;
  end

  always_ff @(posedge clk) begin
    lx8 <= 26'(lxr);
    ly8 <= 26'(lyr);
    for (int i = 0; i < 3; i++) tgt8[i] <= tgt7[i];
  end

  // S9: project lens offsets on each axis
  logic signed [41:0] lr9 [3];
  logic signed [41:0] lu9 [3];
  logic signed [31:0] tgt9 [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      lr9[i]  <= lx8 * rt[i];
      lu9[i]  <= ly8 * upv[i];
      tgt9[i] <= tgt8[i];
    end
  end

  // S10: ray origin on the lens
  logic signed [27:0] org10 [3];
  logic signed [31:0] tgt10 [3];
  logic signed [41:0] lrr [3];
  logic signed [41:0] lur [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lrr[i] = (lr9[i] + 42'sd8192) >>> 14;
      lur[i] = (lu9[i] + 42'sd8192) >>> 14;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      org10[i] <= 28'(pos[i]) + 28'(lrr[i]) + 28'(lur[i]);
      tgt10[i] <= tgt9[i];
    end
  end

  // S11: difference vector
  logic signed [27:0] org11 [3];
  logic signed [31:0] dif11 [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      org11[i] <= org10[i];
      dif11[i] <= tgt10[i] - 32'(org10[i]);
    end
  end

  // S12: magnitude and sign; |dif| stays below 2^30
  logic signed [27:0] org12 [3];
  logic [29:0]        mag12 [3];
  logic [2:0]         neg12;
  logic signed [31:0] absd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) absd[i] = dif11[i][31] ? -dif11[i] : dif11[i];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      org12[i] <= org11[i];
      mag12[i] <= absd[i][29:0];
      neg12[i] <= dif11[i][31];
    end
  end

  // S13: squares
  logic signed [27:0] org13 [3];
  logic [29:0]        mag13 [3];
  logic [2:0]         neg13;
  logic [59:0]        sq13 [3];

  always_ff @(posedge clk) begin
    neg13 <= neg12;
    for (int i = 0; i < 3; i++) begin
      org13[i] <= org12[i];
      mag13[i] <= mag12[i];
      sq13[i]  <= mag12[i] * mag12[i];
    end
  end

  // S14: sum of squares, queue entry
  always_ff @(posedge clk) begin
    push_data.neg   <= neg13;
    push_data.sumsq <= 62'(sq13[0]) + 62'(sq13[1]) + 62'(sq13[2]);
    for (int i = 0; i < 3; i++) begin
      push_data.org[i] <= org13[i];
      push_data.mag[i] <= mag13[i];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tlcrg_queue.sv */
// Queue between the front pipeline and the normalising back end.
`timescale 1ns / 1ps
`default_nettype none
module tlcrg_queue import tlcrg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qent_t  wdata,
  input  logic   pop,
  output qent_t  rdata,
  output qstat_t stat
);

  qent_t          mem [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   count;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == (QAW+1)'(QDEPTH));
  assign rdata      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == QAW'(QDEPTH-1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == QAW'(QDEPTH-1)) ? '0 : rptr + 1'b1;
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tlcrg_back.sv */
// Back end: square root, per-axis divide, near-plane push and output register.
`timescale 1ns / 1ps
`default_nettype none
module tlcrg_back import tlcrg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  head_valid,
  input  qent_t head,
  output logic  pop,
  tlcrg_out_if.source ray
);

  localparam int SQ_STEPS  = 31;
  localparam int DIV_STEPS = 15;
  localparam int NB        = 1 + SQ_STEPS + 1 + DIV_STEPS + 4;

  typedef struct packed {
    logic [2:0][27:0] org;
    logic [2:0][29:0] mag;
    logic [2:0]       neg;
  } carry_t;

  logic          adv;
  logic [NB-1:0] bv;

  // whole back end stalls together when the output beat is not taken
  assign adv       = !bv[NB-1] || ray.ready;
  assign pop       = adv && head_valid;
  assign ray.valid = bv[NB-1];

  always_ff @(posedge clk) begin
    if (rst)      bv <= '0;
    else if (adv) bv <= {bv[NB-2:0], head_valid};
  end

  // square root, one result bit per stage
  logic [61:0] sq_v [SQ_STEPS+1];
  logic [61:0] sq_r [SQ_STEPS+1];
  carry_t      sq_c [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_v[0]     <= head.sumsq;
      sq_r[0]     <= '0;
      sq_c[0].org <= head.org;
      sq_c[0].mag <= head.mag;
      sq_c[0].neg <= head.neg;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam int SH = 2 * (SQ_STEPS - 1) - 2 * k;
    logic [61:0] rb;
    assign rb = sq_r[k] + (62'd1 << SH);
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_c[k+1] <= sq_c[k];
        if (sq_v[k] >= rb) begin
          sq_v[k+1] <= sq_v[k] - rb;
          sq_r[k+1] <= (sq_r[k] >> 1) + (62'd1 << SH);
        end else begin
          sq_v[k+1] <= sq_v[k];
          sq_r[k+1] <= sq_r[k] >> 1;
        end
      end
    end
  end

  // restoring divide of (mag << 14) + len/2 by len, quotient at most 2^14
  logic [30:0] dv_len  [DIV_STEPS+1];
  logic        dv_zero [DIV_STEPS+1];
  logic [45:0] dv_rem  [DIV_STEPS+1][3];
  logic [14:0] dv_q    [DIV_STEPS+1][3];
  carry_t      dv_c    [DIV_STEPS+1];
  logic [30:0] len_s;

  assign len_s = sq_r[SQ_STEPS][30:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_len[0]  <= len_s;
      dv_zero[0] <= (len_s == '0);
      dv_c[0]    <= sq_c[SQ_STEPS];
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= {2'b00, sq_c[SQ_STEPS].mag[i], 14'd0} + 46'(len_s >> 1);
        dv_q[0][i]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - k;
    logic [45:0] dsh;
    assign dsh = 46'(dv_len[k]) << SH;
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_len[k+1]  <= dv_len[k];
        dv_zero[k+1] <= dv_zero[k];
        dv_c[k+1]    <= dv_c[k];
        for (int i = 0; i < 3; i++) begin
          if (dv_rem[k][i] >= dsh) begin
            dv_rem[k+1][i] <= dv_rem[k][i] - dsh;
            dv_q[k+1][i]   <= dv_q[k][i] | (15'd1 << SH);
          end else begin
            dv_rem[k+1][i] <= dv_rem[k][i];
            dv_q[k+1][i]   <= dv_q[k][i];
          end
        end
      end
    end
  end

  // E1: signed direction, zero for a degenerate ray
  logic signed [15:0] e1_dir [3];
  logic [2:0][27:0]   e1_org;
  always_ff @(posedge clk) begin
    if (adv) begin
      e1_org <= dv_c[DIV_STEPS].org;
      for (int i = 0; i < 3; i++) begin
        if (dv_zero[DIV_STEPS])
          e1_dir[i] <= '0;
        else if (dv_c[DIV_STEPS].neg[i])
          e1_dir[i] <= -$signed({1'b0, dv_q[DIV_STEPS][i]});
        else
          e1_dir[i] <= $signed({1'b0, dv_q[DIV_STEPS][i]});
      end
    end
  end

  // E2: near distance along the direction
  logic signed [16:0] near_s;
  logic signed [32:0] e2_p   [3];
  logic signed [15:0] e2_dir [3];
  logic [2:0][27:0]   e2_org;

  assign near_s = $signed({1'b0, cfg.clip[15:0]});

  always_ff @(posedge clk) begin
    if (adv) begin
      e2_org <= e1_org;
      for (int i = 0; i < 3; i++) begin
        e2_p[i]   <= e1_dir[i] * near_s;
        e2_dir[i] <= e1_dir[i];
      end
    end
  end

  // E3: pushed origin in Q.16
  logic signed [28:0] e3_o   [3];
  logic signed [15:0] e3_dir [3];
  logic signed [32:0] pr     [3];

  always_comb begin
    for (int i = 0; i < 3; i++) pr[i] = (e2_p[i] + 33'sd32) >>> 6;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e3_o[i]   <= 29'($signed(e2_org[i])) + 29'(pr[i]);
        e3_dir[i] <= e2_dir[i];
      end
    end
  end

  // E4: output register; origin to Q8.8 with saturation
  logic signed [28:0] orr [3];
  logic signed [15:0] osat [3];
  logic signed [15:0] o_org [3];
  logic signed [15:0] o_dir [3];
  logic [15:0]        o_len;
  logic [15:0]        far_d, near_d;

  assign far_d  = cfg.clip[31:16];
  assign near_d = cfg.clip[15:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      orr[i] = (e3_o[i] + 29'sd128) >>> 8;
      if (orr[i] > 29'sd32767)       osat[i] = 16'sh7FFF;
      else if (orr[i] < -29'sd32768) osat[i] = 16'sh8000;
      else                           osat[i] = orr[i][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        o_org[i] <= osat[i];
        o_dir[i] <= e3_dir[i];
      end
      o_len <= (far_d > near_d) ? far_d - near_d : '0;
    end
  end

  assign ray.origin_x    = o_org[0];
  assign ray.origin_y    = o_org[1];
  assign ray.origin_z    = o_org[2];
  assign ray.direction_x = o_dir[0];
  assign ray.direction_y = o_dir[1];
  assign ray.direction_z = o_dir[2];
  assign ray.ray_length  = o_len;

endmodule
`default_nettype wire

/* hw/rtl/thin_lens_camera_ray_generator_unit.sv */
// An accepted pixel beat runs through the front pipeline, the queue and the back end
// (31-stage square root, 15-stage divide, near push, output register) to its ray beat.
// Throughput: one ray per cycle while ray.ready is high; the 32-entry queue and its
// credit count set how many beats may be in flight before pixel.ready drops.
// Reset (synchronous, rst high) empties the pipelines and queue and loads register
// defaults: focus 1.0, pinhole aperture, plane 2.0 x 2.0, far 255.996, near 0.
`timescale 1ns / 1ps
`default_nettype none
module thin_lens_camera_ray_generator_unit import tlcrg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  tlcrg_in_if.sink          pixel,
  tlcrg_out_if.source       ray,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  cfg_t   cfg;
  logic   push, pop;
  qent_t  push_data, head;
  qstat_t qstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cam_pos    <= '0;
      cfg.fwd_axis   <= '0;
      cfg.right_axis <= '0;
      cfg.up_axis    <= '0;
      cfg.focus      <= FOCUS_RST;
      cfg.aperture   <= '0;
      cfg.plane      <= PLANE_RST;
      cfg.clip       <= CLIP_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CAM_POS:  cfg.cam_pos    <= cfg_data;
        REG_FORWARD:  cfg.fwd_axis   <= cfg_data;
        REG_RIGHT:    cfg.right_axis <= cfg_data;
        REG_UP:       cfg.up_axis    <= cfg_data;
        REG_FOCUS:    cfg.focus      <= cfg_data[15:0];
        REG_APERTURE: cfg.aperture   <= cfg_data[15:0];
        REG_PLANE:    cfg.plane      <= cfg_data[31:0];
        REG_CLIP:     cfg.clip       <= cfg_data[31:0];
        default:      ;
      endcase
    end
  end

  tlcrg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .cfg       (cfg),
    .pop       (pop),
    .push      (push),
    .push_data (push_data)
  );

  tlcrg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_data),
    .pop   (pop),
    .rdata (head),
    .stat  (qstat)
  );

  tlcrg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (!qstat.empty),
    .head       (head),
    .pop        (pop),
    .ray        (ray)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("front pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("back end popped an empty queue");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !pixel.ready)
    else $error("input open while queue full: credit count out of step");
`endif

endmodule
`default_nettype wire
